@@ hw/rtl/gale_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gale_pkg
// Shared types and codes of the graph adjacency list engine.
// ----------------------------------------------------------------------------
package gale_pkg;

	localparam int VTX_W  = 6;
	localparam int DATA_W = 32;

	localparam logic signed [DATA_W-1:0] MISSING_WEIGHT = -32'sd1;

	// opcode codes of the request item, plus an internal no-op
	typedef enum logic [3:0] {
		OP_ADDV = 4'd0,
		OP_REMV = 4'd1,
		OP_ADDE = 4'd2,
		OP_REME = 4'd3,
		OP_ADJ  = 4'd4,
		OP_NB   = 4'd5,
		OP_GETV = 4'd6,
		OP_SETV = 4'd7,
		OP_GETE = 4'd8,
		OP_SETE = 4'd9,
		OP_NOP  = 4'd15
	} op_t;

	typedef struct packed {
		logic [3:0]               opcode;
		logic [VTX_W-1:0]         first_vertex;
		logic [VTX_W-1:0]         second_vertex;
		logic signed [DATA_W-1:0] data_value;
	} req_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic                     found_flag;
		logic [VTX_W-1:0]         neighbour_index;
		logic                     neighbour_valid;
		logic                     last_item;
	} rsp_item_t;

	// classified command handed from front to back
	typedef struct packed {
		op_t                      op;
		logic [VTX_W-1:0]         x;
		logic [VTX_W-1:0]         y;
		logic signed [DATA_W-1:0] data;
		logic                     xok;
		logic                     yok;
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_DEG,
		S_DEGW,
		S_FRD,
		S_FCMP,
		S_FDONE,
		S_APP,
		S_PRD,
		S_PWR,
		S_NRD,
		S_NOUT,
		S_VRD,
		S_VLAT,
		S_EMIT
	} seq_state_t;

endpackage
`default_nettype wire

@@ hw/rtl/gale_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gale_front
// Accepts request items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module gale_front import gale_pkg::*; #(
	parameter int VERTICES = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire req_item_t req,
	output logic           cmd_valid,
	input  wire logic      cmd_ready,
	output cmd_t           cmd
);

	cmd_t       q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       dec;
	logic       push;
	logic       pop;

	always_comb begin
		dec.x    = req.first_vertex;
		dec.y    = req.second_vertex;
		dec.data = req.data_value;
		dec.xok  = (32'(req.first_vertex) < 32'(VERTICES));
		dec.yok  = (32'(req.second_vertex) < 32'(VERTICES));
		if (req.opcode <= 4'(OP_SETE)) begin
			dec.op = op_t'(req.opcode);
		end else begin
			dec.op = OP_NOP;
		end
	end

	assign req_ready = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_mem_q[rd_ptr_q];
	assign push      = req_valid && req_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/gale_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gale_back
// Sequencer over the vertex and adjacency stores, with the result register.
// ----------------------------------------------------------------------------
module gale_back import gale_pkg::*; #(
	parameter int VERTICES   = 64,
	parameter int VALUE_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic directed_mode,
	input  wire logic cmd_valid,
	output logic      cmd_ready,
	input  wire cmd_t cmd,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_item_t rsp
);

	localparam int IW        = (VERTICES > 1) ? $clog2(VERTICES) : 1;
	localparam int DW        = $clog2(VERTICES + 1);
	localparam int AW        = 2 * IW;
	localparam int ADJ_DEPTH = 1 << AW;
	localparam int VB        = VALUE_BITS;

	// stores
	logic [VTX_W-1:0]   tgt_mem [ADJ_DEPTH];
	logic signed [VB-1:0] wgt_mem [ADJ_DEPTH];
	logic [DW-1:0]      deg_mem [VERTICES];
	logic signed [VB-1:0] val_mem [VERTICES];
	logic [VERTICES-1:0] dvld_q;
	logic [VERTICES-1:0] vvld_q;
	logic [VERTICES-1:0] ex_q;

	// read data
	logic [VTX_W-1:0]     tgt_rd_q;
	logic signed [VB-1:0] wgt_rd_q;
	logic [DW-1:0]        deg_rd_q;
	logic                 deg_ok_q;
	logic signed [VB-1:0] val_rd_q;
	logic                 val_ok_q;

	// sequencer state
	seq_state_t           state_q, state_d;
	cmd_t                 cmd_q;
	logic [IW-1:0]        fs_q;
	logic [VTX_W-1:0]     ft_q;
	logic [DW-1:0]        d_q;
	logic [DW-1:0]        j_q;
	logic [DW-1:0]        k_q;
	logic [IW-1:0]        vi_q;
	logic [IW-1:0]        pos_q;
	logic                 phase_q;
	logic                 found_q;
	logic signed [VB-1:0] w_q;
	rsp_item_t            res_q;
	rsp_item_t            out_q;
	logic                 out_valid_q;

	// control
	logic                 out_free;
	logic                 xe, ye, ok2, hit, scan_end, nb_last, rev_add, rev_purge, vi_last;
	logic [DW-1:0]        deg_cur;
	logic                 adj_re;
	logic [AW-1:0]        adj_raddr;
	logic                 tgt_we, wgt_we;
	logic [AW-1:0]        adj_waddr;
	logic [VTX_W-1:0]     tgt_wdata;
	logic signed [VB-1:0] wgt_wdata;
	logic                 deg_we;
	logic [IW-1:0]        deg_waddr;
	logic [DW-1:0]        deg_wdata;
	logic                 val_we, ex_set, ex_clr;
	logic                 emit;
	rsp_item_t            emit_item;

	assign out_free  = !out_valid_q || rsp_ready;
	assign xe        = cmd_q.xok && ex_q[IW'(cmd_q.x)];
	assign ye        = cmd_q.yok && ex_q[IW'(cmd_q.y)];
	assign ok2       = cmd_q.xok && cmd_q.yok;
	assign hit       = (tgt_rd_q == ft_q);
	assign scan_end  = (j_q == d_q);
	assign nb_last   = ((j_q + DW'(1)) == d_q);
	assign deg_cur   = deg_ok_q ? deg_rd_q : '0;
	assign rev_add   = !phase_q && !directed_mode && (cmd_q.x != cmd_q.y);
	assign rev_purge = !phase_q && !directed_mode;
	assign vi_last   = (vi_q == IW'(VERTICES - 1));
	assign adj_raddr = {fs_q, j_q[IW-1:0]};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (cmd_valid) state_d = S_DISP;
			S_DISP: begin
				unique case (cmd_q.op)
					OP_GETV: state_d = cmd_q.xok ? S_VRD : S_EMIT;
					OP_REMV: state_d = xe ? S_DEG : S_IDLE;
					OP_ADDE,
					OP_REME: state_d = (xe && ye) ? S_DEG : S_IDLE;
					OP_ADJ,
					OP_NB:   state_d = xe ? S_DEG : S_EMIT;
					OP_GETE: state_d = ok2 ? S_DEG : S_EMIT;
					OP_SETE: state_d = ok2 ? S_DEG : S_IDLE;
					default: state_d = S_IDLE;
				endcase
			end
			S_DEG: state_d = S_DEGW;
			S_DEGW: begin
				unique case (cmd_q.op)
					OP_NB:   state_d = (deg_cur == '0) ? S_EMIT : S_NRD;
					OP_REMV,
					OP_REME: state_d = S_PRD;
					default: state_d = S_FRD;
				endcase
			end
			S_FRD:  state_d = scan_end ? S_FDONE : S_FCMP;
			S_FCMP: state_d = hit ? S_FDONE : S_FRD;
			S_FDONE: begin
				unique case (cmd_q.op)
					OP_ADJ,
					OP_GETE: state_d = S_EMIT;
					OP_ADDE: state_d = found_q ? S_IDLE : S_APP;
					default: state_d = S_IDLE;
				endcase
			end
			S_APP: state_d = rev_add ? S_DEG : S_IDLE;
			S_PRD: begin
				if (!scan_end) begin
					state_d = S_PWR;
				end else if (cmd_q.op == OP_REMV) begin
					state_d = vi_last ? S_IDLE : S_DEG;
				end else begin
					state_d = rev_purge ? S_DEG : S_IDLE;
				end
			end
			S_PWR:  state_d = S_PRD;
			S_NRD:  state_d = S_NOUT;
			S_NOUT: if (out_free) state_d = nb_last ? S_IDLE : S_NRD;
			S_VRD:  state_d = S_VLAT;
			S_VLAT: state_d = S_EMIT;
			S_EMIT: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd_ready = (state_q == S_IDLE);
		adj_re    = 1'b0;
		tgt_we    = 1'b0;
		wgt_we    = 1'b0;
		adj_waddr = {fs_q, k_q[IW-1:0]};
		tgt_wdata = tgt_rd_q;
		wgt_wdata = wgt_rd_q;
		deg_we    = 1'b0;
		deg_waddr = fs_q;
		deg_wdata = k_q;
		val_we    = 1'b0;
		ex_set    = 1'b0;
		ex_clr    = 1'b0;
		emit      = 1'b0;
		emit_item = res_q;
		unique case (state_q)
			S_DISP: begin
				if (cmd_q.op == OP_ADDV && cmd_q.xok) ex_set = 1'b1;
				if (cmd_q.op == OP_SETV && cmd_q.xok) val_we = 1'b1;
				if (cmd_q.op == OP_REMV && xe) begin
					ex_clr    = 1'b1;
					deg_we    = 1'b1;
					deg_waddr = IW'(cmd_q.x);
					deg_wdata = '0;
				end
			end
			S_FRD: adj_re = !scan_end;
			S_FDONE: begin
				if (cmd_q.op == OP_SETE && found_q) begin
					wgt_we    = 1'b1;
					adj_waddr = {fs_q, pos_q};
					wgt_wdata = VB'(cmd_q.data);
				end
			end
			S_APP: begin
				tgt_we    = 1'b1;
				wgt_we    = 1'b1;
				adj_waddr = {fs_q, d_q[IW-1:0]};
				tgt_wdata = ft_q;
				wgt_wdata = '0;
				deg_we    = 1'b1;
				deg_wdata = d_q + DW'(1);
			end
			S_PRD: begin
				adj_re = !scan_end;
				deg_we = scan_end;
			end
			S_PWR: begin
				tgt_we = !hit;
				wgt_we = !hit;
			end
			S_NRD: adj_re = 1'b1;
			S_NOUT: begin
				emit                      = out_free;
				emit_item                 = '0;
				emit_item.neighbour_index = tgt_rd_q;
				emit_item.neighbour_valid = 1'b1;
				emit_item.last_item       = nb_last;
			end
			S_EMIT: emit = out_free;
			default: ;
		endcase
	end

	// stores and read ports
	always_ff @(posedge clk) begin
		if (tgt_we) tgt_mem[adj_waddr] <= tgt_wdata;
		if (wgt_we) wgt_mem[adj_waddr] <= wgt_wdata;
		if (adj_re) begin
			tgt_rd_q <= tgt_mem[adj_raddr];
			wgt_rd_q <= wgt_mem[adj_raddr];
		end
		if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
		if (val_we) val_mem[IW'(cmd_q.x)] <= VB'(cmd_q.data);
		deg_rd_q <= deg_mem[fs_q];
		val_rd_q <= val_mem[fs_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld_q   <= '0;
			vvld_q   <= '0;
			ex_q     <= '0;
			deg_ok_q <= 1'b0;
			val_ok_q <= 1'b0;
		end else begin
			if (deg_we) dvld_q[deg_waddr] <= 1'b1;
			if (val_we) vvld_q[IW'(cmd_q.x)] <= 1'b1;
			if (ex_set) ex_q[IW'(cmd_q.x)] <= 1'b1;
			if (ex_clr) ex_q[IW'(cmd_q.x)] <= 1'b0;
			deg_ok_q <= dvld_q[fs_q];
			val_ok_q <= vvld_q[fs_q];
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (cmd_valid) cmd_q <= cmd;
			S_DISP: begin
				res_q           <= '0;
				res_q.last_item <= 1'b1;
				if (cmd_q.op == OP_GETE) res_q.read_value <= MISSING_WEIGHT;
				phase_q <= 1'b0;
				vi_q    <= '0;
				ft_q    <= (cmd_q.op == OP_REMV) ? cmd_q.x : cmd_q.y;
				fs_q    <= (cmd_q.op == OP_REMV) ? '0 : IW'(cmd_q.x);
			end
			S_DEGW: begin
				d_q     <= deg_cur;
				j_q     <= '0;
				k_q     <= '0;
				found_q <= 1'b0;
			end
			S_FCMP: begin
				if (hit) begin
					found_q <= 1'b1;
					pos_q   <= j_q[IW-1:0];
					w_q     <= wgt_rd_q;
				end else begin
					j_q <= j_q + DW'(1);
				end
			end
			S_FDONE: begin
				res_q.found_flag <= found_q;
				if (cmd_q.op == OP_GETE && found_q) res_q.read_value <= 32'(w_q);
			end
			S_APP: begin
				phase_q <= 1'b1;
				fs_q    <= IW'(cmd_q.y);
				ft_q    <= cmd_q.x;
			end
			S_PRD: begin
				if (scan_end && cmd_q.op == OP_REMV) begin
					vi_q <= vi_q + IW'(1);
					fs_q <= vi_q + IW'(1);
				end else if (scan_end) begin
					phase_q <= 1'b1;
					fs_q    <= IW'(cmd_q.y);
					ft_q    <= cmd_q.x;
				end
			end
			S_PWR: begin
				if (!hit) k_q <= k_q + DW'(1);
				j_q <= j_q + DW'(1);
			end
			S_NOUT: if (out_free) j_q <= j_q + DW'(1);
			S_VLAT: res_q.read_value <= val_ok_q ? 32'(val_rd_q) : '0;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (emit) out_q <= emit_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
`default_nettype wire

@@ hw/rtl/graph_adjacency_list_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// graph_adjacency_list_engine
// Graph store with per-vertex values and ordered, weighted adjacency lists.
// ----------------------------------------------------------------------------
// A two-entry command queue decouples the request side from a sequencer that
// works on one command at a time against single-port adjacency memories
// (VERTICES x VERTICES entries, registered read). A lookup (adjacent, get
// or set edge, add edge), a neighbour list and a remove edge walk the list
// entry by entry, each entry taking a read state and then a compare, output
// or write state, since the memory read is registered; an undirected add of
// a new edge and an undirected remove edge also walk the reverse list, and
// remove vertex walks every list. No clearing pass is needed after reset:
// degree and value stores have per-entry valid bits, existence marks are
// plain registers.
module graph_adjacency_list_engine import gale_pkg::*; #(
	parameter int VERTICES   = 64,
	parameter int VALUE_BITS = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire req_item_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output rsp_item_t      rsp,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic      cfg_data
);

	logic directed_mode_q;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	// mode register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			directed_mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			directed_mode_q <= cfg_data;
		end
	end

	// front: classify and queue
	gale_front #(
		.VERTICES(VERTICES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// back: sequencer over the stores
	gale_back #(
		.VERTICES  (VERTICES),
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.directed_mode(directed_mode_q),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp          (rsp)
	);

	// only neighbour lists give more than one item per command
	a_multi_is_nb: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last_item |-> rsp.neighbour_valid)
		else $error("non-final item outside a neighbour list");

	// a found edge never travels with a neighbour entry
	a_found_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found_flag |-> rsp.last_item && !rsp.neighbour_valid)
		else $error("found flag on a neighbour item");

	// empty neighbour slot carries index zero
	a_nb_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.neighbour_valid |-> rsp.neighbour_index == '0)
		else $error("stray neighbour index");

	// mode write lands
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> directed_mode_q == $past(cfg_data))
		else $error("mode write lost");

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the graph adjacency list engine. A predictor keeps
// its own copy of the graph, works out the expected responses of every
// accepted request item, and a checker compares each response field by field.
// Directed cases, a full-degree list, back-pressure and random traffic run;
// the undirected test and the random traffic cover both edge modes.
// ----------------------------------------------------------------------------
module tb_top;
	import gale_pkg::*;

	localparam int NV        = 64;
	localparam int IDLE_WAIT = 9000;   // worst remove-vertex walk, rounded up
	localparam int HOLD_LEN  = 600;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_item_t rsp;
	logic      cfg_valid;
	logic      cfg_ready;
	logic      cfg_data;

	graph_adjacency_list_engine #(.VERTICES(NV), .VALUE_BITS(DATA_W)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// graph copy of the predictor
	logic                     vtx_live [NV];
	logic signed [DATA_W-1:0] vtx_val  [NV];
	int                       vtx_deg  [NV];
	logic [VTX_W-1:0]         edge_to  [NV][NV];
	logic signed [DATA_W-1:0] edge_wt  [NV][NV];
	logic                     directed_q;

	rsp_item_t expected_rsps[$];

	int mismatches;
	int unexpected;
	int rsp_seen;
	int items_sent;
	int burst_left;
	int stall_mode;
	int stall_timer;

	event hold_go;
	logic hold_on;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit, far above the slowest legal run
	initial begin
		#200ms;
		$display("** graph_adjacency_list_engine: FAILED **");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void exp_add(rsp_item_t r);
		expected_rsps = {expected_rsps, r};
	endfunction

	function automatic int edge_pos(int x, int y);
		for (int i = 0; i < vtx_deg[x]; i++)
			if (int'(edge_to[x][i]) == y)
				return i;
		return -1;
	endfunction

	function automatic void edge_append(int x, int y);
		int d;
		d = vtx_deg[x];
		if (edge_pos(x, y) >= 0 || d >= NV)
			return;
		edge_to[x][d] = VTX_W'(y);
		edge_wt[x][d] = '0;
		vtx_deg[x] = d + 1;
	endfunction

	// drop every entry of list x that points to y, keeping order
	function automatic void edge_purge(int x, int y);
		int k;
		k = 0;
		for (int i = 0; i < vtx_deg[x]; i++)
			if (int'(edge_to[x][i]) != y) begin
				edge_to[x][k] = edge_to[x][i];
				edge_wt[x][k] = edge_wt[x][i];
				k++;
			end
		vtx_deg[x] = k;
	endfunction

	function automatic rsp_item_t mk_rsp(logic signed [DATA_W-1:0] v, logic f,
			logic [VTX_W-1:0] nb, logic nbv, logic last);
		rsp_item_t r;
		r.read_value      = v;
		r.found_flag      = f;
		r.neighbour_index = nb;
		r.neighbour_valid = nbv;
		r.last_item       = last;
		return r;
	endfunction

	// apply one accepted request item and queue the responses it causes
	function automatic void graph_apply(req_item_t it);
		int  x, y, p, d;
		logic xe, ye;
		x  = int'(it.first_vertex);
		y  = int'(it.second_vertex);
		xe = vtx_live[x];
		ye = vtx_live[y];
		case (it.opcode)
			OP_ADDV: vtx_live[x] = 1'b1;
			OP_REMV: begin
				if (xe) begin
					vtx_live[x] = 1'b0;
					vtx_deg[x]  = 0;
					for (int i = 0; i < NV; i++)
						edge_purge(i, x);
				end
			end
			OP_ADDE: begin
				if (xe && ye && edge_pos(x, y) < 0) begin
					edge_append(x, y);
					if (!directed_q && x != y)
						edge_append(y, x);
				end
			end
			OP_REME: begin
				if (xe && ye) begin
					edge_purge(x, y);
					if (!directed_q)
						edge_purge(y, x);
				end
			end
			OP_ADJ: exp_add(mk_rsp('0, xe && edge_pos(x, y) >= 0, '0, 1'b0, 1'b1));
			OP_NB: begin
				d = xe ? vtx_deg[x] : 0;
				if (d == 0)
					exp_add(mk_rsp('0, 1'b0, '0, 1'b0, 1'b1));
				for (int i = 0; i < d; i++)
					exp_add(mk_rsp('0, 1'b0, edge_to[x][i], 1'b1, i + 1 == d));
			end
			OP_GETV: exp_add(mk_rsp(vtx_val[x], 1'b0, '0, 1'b0, 1'b1));
			OP_SETV: vtx_val[x] = it.data_value;
			OP_GETE: begin
				p = edge_pos(x, y);
				if (p < 0)
					exp_add(mk_rsp(MISSING_WEIGHT, 1'b0, '0, 1'b0, 1'b1));
				else
					exp_add(mk_rsp(edge_wt[x][p], 1'b1, '0, 1'b0, 1'b1));
			end
			OP_SETE: begin
				p = edge_pos(x, y);
				if (p >= 0)
					edge_wt[x][p] = it.data_value;
			end
			default: ;  // unknown codes are dropped
		endcase
	endfunction

	// ---------------------------------------------------------------- checker

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_seen++;
			if (expected_rsps.size() == 0) begin
				unexpected++;
				if (unexpected + mismatches <= 10)
					$display("unexpected response item: %p", rsp);
			end else begin
				rsp_item_t e;
				e = expected_rsps.pop_front();
				if (rsp.read_value !== e.read_value || rsp.found_flag !== e.found_flag ||
						rsp.neighbour_index !== e.neighbour_index ||
						rsp.neighbour_valid !== e.neighbour_valid ||
						rsp.last_item !== e.last_item) begin
					mismatches++;
					if (unexpected + mismatches <= 10)
						$display("mismatch: expected %p, got %p", e, rsp);
				end
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	// long hold, counted in its own process
	initial begin
		hold_on = 1'b0;
		forever begin
			@(hold_go);
			hold_on <= 1'b1;
			repeat (HOLD_LEN) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	// stall pattern changes every so often; a long hold overrides it
	always @(posedge clk) begin
		if (stall_timer == 0) begin
			stall_mode  <= $urandom_range(0, 2);
			stall_timer <= $urandom_range(20, 120);
		end else
			stall_timer <= stall_timer - 1;
		if (hold_on)
			rsp_ready <= 1'b0;
		else
			case (stall_mode)
				0:       rsp_ready <= 1'b1;
				1:       rsp_ready <= ($urandom_range(0, 3) != 0);
				default: rsp_ready <= (stall_timer % 3 != 0);
			endcase
	end

	// ---------------------------------------------------------------- sender

	// offer one request item, hold it until taken, then maybe leave a gap
	task automatic send_item(req_item_t it);
		int gap;
		req       <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		graph_apply(it);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic req_item_t mk_req(op_t op, int x, int y, logic [31:0] v);
		req_item_t it;
		it.opcode        = op;
		it.first_vertex  = VTX_W'(x);
		it.second_vertex = VTX_W'(y);
		it.data_value    = v;
		return it;
	endfunction

	// stop offering, let every response arrive and any silent work finish
	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic write_mode(logic m);
		cfg_data  <= m;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid  <= 1'b0;
		directed_q = m;
	endtask

	// mostly a small vertex set so the graph gets dense
	function automatic int pick_vertex();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(0, 7);
		return $urandom_range(0, NV - 1);
	endfunction

	function automatic req_item_t rand_item();
		int  w;
		logic [3:0] op;
		req_item_t it;
		w = $urandom_range(0, 99);
		if (w < 14)      op = OP_ADDV;
		else if (w < 18) op = OP_REMV;
		else if (w < 38) op = OP_ADDE;
		else if (w < 44) op = OP_REME;
		else if (w < 54) op = OP_ADJ;
		else if (w < 64) op = OP_NB;
		else if (w < 70) op = OP_GETV;
		else if (w < 77) op = OP_SETV;
		else if (w < 87) op = OP_GETE;
		else if (w < 96) op = OP_SETE;
		else             op = 4'($urandom_range(10, 15));
		it.opcode        = op;
		it.first_vertex  = VTX_W'(pick_vertex());
		it.second_vertex = VTX_W'(pick_vertex());
		it.data_value    = $urandom;
		return it;
	endfunction

	// ---------------------------------------------------------------- tests

	// extremes of the fields, every opcode but remove edge, missing vertex and edge cases
	task automatic test_directed_basics();
		send_item(mk_req(OP_GETV, 10, 0, 0));             // never written value
		send_item(mk_req(OP_NB, 5, 0, 0));                // missing vertex
		send_item(mk_req(OP_ADDV, 0, 0, 0));
		send_item(mk_req(OP_ADDV, 63, 0, 0));
		send_item(mk_req(OP_ADDV, 63, 0, 0));             // already present
		send_item(mk_req(OP_NB, 0, 0, 0));                // empty list
		send_item(mk_req(OP_SETV, 63, 0, 32'h8000_0000));
		send_item(mk_req(OP_SETV, 0, 0, 32'h7fff_ffff));
		send_item(mk_req(OP_GETV, 63, 0, 0));
		send_item(mk_req(OP_GETV, 0, 0, 0));
		send_item(mk_req(OP_ADDE, 0, 63, 0));
		send_item(mk_req(OP_ADDE, 0, 63, 0));             // duplicate
		send_item(mk_req(OP_ADDE, 0, 5, 0));              // target missing
		send_item(mk_req(OP_ADJ, 0, 63, 0));
		send_item(mk_req(OP_ADJ, 63, 0, 0));              // one-way only
		send_item(mk_req(OP_GETE, 0, 63, 0));             // fresh weight
		send_item(mk_req(OP_SETE, 0, 63, 32'hffff_ffff));
		send_item(mk_req(OP_GETE, 0, 63, 0));
		send_item(mk_req(OP_GETE, 63, 0, 0));             // missing edge
		send_item(mk_req(OP_SETE, 63, 0, 32'h1234_5678)); // missing edge
		send_item(mk_req(OP_ADDE, 0, 0, 0));              // self-loop
		send_item(mk_req(OP_NB, 0, 0, 0));
		send_item(mk_req(OP_NOP, 0, 0, 0));               // unknown code
		send_item(mk_req(OP_REMV, 63, 0, 0));             // purge edges to it
		send_item(mk_req(OP_NB, 0, 0, 0));
		send_item(mk_req(OP_GETV, 63, 0, 0));             // value kept
		wait_idle();
	endtask

	// undirected mode: reverse edges, single self-loop, reverse already there
	task automatic test_undirected();
		write_mode(1'b0);
		send_item(mk_req(OP_ADDV, 1, 0, 0));
		send_item(mk_req(OP_ADDV, 2, 0, 0));
		send_item(mk_req(OP_ADDE, 1, 2, 0));
		send_item(mk_req(OP_ADJ, 2, 1, 0));
		send_item(mk_req(OP_SETE, 2, 1, 32'h0000_0055));
		send_item(mk_req(OP_GETE, 1, 2, 0));              // untouched reverse
		send_item(mk_req(OP_ADDE, 1, 1, 0));
		send_item(mk_req(OP_NB, 1, 0, 0));
		send_item(mk_req(OP_ADDE, 0, 1, 0));              // vertex 0 still present
		send_item(mk_req(OP_NB, 0, 0, 0));
		send_item(mk_req(OP_REME, 2, 1, 0));
		send_item(mk_req(OP_NB, 1, 0, 0));
		wait_idle();
		write_mode(1'b1);
		send_item(mk_req(OP_ADDE, 2, 1, 0));
		wait_idle();
		write_mode(1'b0);
		send_item(mk_req(OP_ADDE, 1, 2, 0));              // reverse already present
		send_item(mk_req(OP_NB, 2, 0, 0));
		send_item(mk_req(OP_REMV, 1, 0, 0));
		send_item(mk_req(OP_NB, 2, 0, 0));
		send_item(mk_req(OP_NB, 0, 0, 0));
		wait_idle();
		write_mode(1'b1);
		wait_idle();
	endtask

	// one vertex pointing at every vertex: the longest neighbour list
	task automatic test_full_list();
		for (int v = 0; v < NV; v++)
			send_item(mk_req(OP_ADDV, v, 0, 0));
		for (int v = NV - 1; v >= 0; v--)
			send_item(mk_req(OP_ADDE, 7, v, 0));
		send_item(mk_req(OP_NB, 7, 0, 0));
		send_item(mk_req(OP_ADDE, 7, 3, 0));              // list full and duplicate
		send_item(mk_req(OP_GETE, 7, 0, 0));
		wait_idle();
	endtask

	// receiver holds off while queries keep coming, so the input backs up
	task automatic test_backpressure();
		-> hold_go;
		for (int i = 0; i < 20; i++)
			send_item(mk_req(i % 2 ? OP_GETV : OP_NB, $urandom_range(0, 7), 0, 0));
		wait_idle();
	endtask

	task automatic test_random(int count, logic m);
		int n;
		req_item_t it;
		write_mode(m);
		n = 0;
		while (n < count) begin
			it = rand_item();
			send_item(it);
			if (it.opcode <= OP_SETE)
				n++;
		end
		wait_idle();
	endtask

	initial begin
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		rsp_ready   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = 1'b1;
		stall_mode  = 0;
		stall_timer = 0;
		burst_left  = 4;
		mismatches  = 0;
		unexpected  = 0;
		rsp_seen    = 0;
		items_sent  = 0;
		directed_q  = 1'b1;
		for (int v = 0; v < NV; v++) begin
			vtx_live[v] = 1'b0;
			vtx_val[v]  = '0;
			vtx_deg[v]  = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_basics();
		test_undirected();
		test_full_list();
		test_backpressure();
		test_random(50, 1'b1);
		test_random(50, 1'b0);
		test_random(24, 1'b1);

		$display("run covered %0d request items and %0d response items in both edge modes,",
			items_sent, rsp_seen);
		$display("with a full-degree list, a long response hold and random stalls");
		if (mismatches == 0 && unexpected == 0 && expected_rsps.size() == 0)
			$display("** graph_adjacency_list_engine: PASSED **");
		else begin
			$display("%0d mismatches, %0d unexpected, %0d missing", mismatches, unexpected,
				expected_rsps.size());
			$display("** graph_adjacency_list_engine: FAILED **");
		end
		$finish;
	end

endmodule
